// File: rtl/core/cpm_pkg.sv
// Package for the calibrated point mapper: configuration, queue item and
// divider lane types, register indexes and the shared long-division step.
// No dependencies.
`default_nettype none

package cpm_pkg;

	localparam int unsigned RAW_W          = 10;
	localparam int unsigned SCR_W          = 12;
	localparam int unsigned MARGIN_W       = 8;
	localparam int unsigned PROD_W         = RAW_W + SCR_W;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 12;
	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES     = SCR_W / BITS_PER_STAGE;
	localparam int unsigned QUEUE_DEPTH    = 2;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_X_MIN     = 3'd0,
		REG_CAL_X_MAX     = 3'd1,
		REG_CAL_Y_MIN     = 3'd2,
		REG_CAL_Y_MAX     = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5,
		REG_EDGE_MARGIN   = 3'd6
	} cpm_reg_t;

	// How an axis gets its mapped value
	typedef enum logic [1:0] {
		MAP_DIV  = 2'd0,
		MAP_ZERO = 2'd1,
		MAP_FULL = 2'd2
	} cpm_cls_t;

	typedef struct packed {
		logic [RAW_W-1:0]    cal_x_min;
		logic [RAW_W-1:0]    cal_x_max;
		logic [RAW_W-1:0]    cal_y_min;
		logic [RAW_W-1:0]    cal_y_max;
		logic [SCR_W-1:0]    screen_width;
		logic [SCR_W-1:0]    screen_height;
		logic [MARGIN_W-1:0] edge_margin;
	} cpm_cfg_t;

	// One axis in the divider: partial remainder, and a word that shifts
	// dividend bits out at the top while quotient bits enter at the bottom
	typedef struct packed {
		logic [RAW_W-1:0] rem;
		logic [SCR_W-1:0] rq;
		logic [RAW_W-1:0] span;
		cpm_cls_t         cls;
		logic [SCR_W-1:0] size;
	} cpm_lane_t;

	typedef struct packed {
		cpm_lane_t           x;
		cpm_lane_t           y;
		logic [MARGIN_W-1:0] margin;
	} cpm_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cpm_qstat_t;

	// One restoring long-division step; the remainder always stays below span
	function automatic cpm_lane_t lane_step(cpm_lane_t l);
		logic [RAW_W:0] t;
		cpm_lane_t      r;
		r = l;
		t = {l.rem, l.rq[SCR_W-1]};
		if (t >= {1'b0, l.span}) begin
			r.rem = RAW_W'(t - {1'b0, l.span});
			r.rq  = {l.rq[SCR_W-2:0], 1'b1};
		end else begin
			r.rem = t[RAW_W-1:0];
			r.rq  = {l.rq[SCR_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/cpm_front.sv
// Front end of the point mapper: takes a point, classifies each axis against
// the calibration span and forms the scaled numerator. Uses cpm_pkg.
`default_nettype none

module cpm_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [cpm_pkg::RAW_W-1:0]   dot_x,
	input  wire logic [cpm_pkg::RAW_W-1:0]   dot_y,
	input  wire cpm_pkg::cpm_cfg_t           cfg,
	input  wire cpm_pkg::cpm_qstat_t         qstat,
	output logic                             push,
	output cpm_pkg::cpm_item_t               item
);
	import cpm_pkg::*;

	logic                vld_s1;
	logic                accept;
	logic [RAW_W-1:0]    diff_x, diff_y, span_x, span_y;
	cpm_cls_t            cls_x, cls_y;
	logic [RAW_W-1:0]    diff_x_s1, diff_y_s1, span_x_s1, span_y_s1;
	cpm_cls_t            cls_x_s1, cls_y_s1;
	logic [SCR_W-1:0]    size_x_s1, size_y_s1;
	logic [MARGIN_W-1:0] margin_s1;
	logic [PROD_W-1:0]   num_x, num_y;

	// Hold the stage while the queue has no room
	assign busy   = vld_s1 && qstat.full;
	assign accept = start && !busy;
	assign push   = vld_s1 && !qstat.full;

	// Classify x: below span, above span, empty span, or inside
	always_comb begin
		span_x = cfg.cal_x_max - cfg.cal_x_min;
		diff_x = dot_x - cfg.cal_x_min;
		if (dot_x < cfg.cal_x_min) begin
			cls_x = MAP_ZERO;
		end else if (dot_x > cfg.cal_x_max) begin
			cls_x = MAP_FULL;
		end else if (span_x == '0) begin
			cls_x = MAP_ZERO;
		end else begin
			cls_x = MAP_DIV;
		end
		// Keep the divider harmless on lanes that bypass it
		if (cls_x != MAP_DIV) begin
			diff_x = '0;
			span_x = RAW_W'(1);
		end
	end

	// Classify y the same way
	always_comb begin
		span_y = cfg.cal_y_max - cfg.cal_y_min;
		diff_y = dot_y - cfg.cal_y_min;
		if (dot_y < cfg.cal_y_min) begin
			cls_y = MAP_ZERO;
		end else if (dot_y > cfg.cal_y_max) begin
			cls_y = MAP_FULL;
		end else if (span_y == '0) begin
			cls_y = MAP_ZERO;
		end else begin
			cls_y = MAP_DIV;
		end
		if (cls_y != MAP_DIV) begin
			diff_y = '0;
			span_y = RAW_W'(1);
		end
	end

	// Stage valid: set on a new transaction, drop once pushed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture the classified point with a snapshot of scales and margin
	always_ff @(posedge clk) begin
		if (accept) begin
			diff_x_s1 <= diff_x;
			diff_y_s1 <= diff_y;
			span_x_s1 <= span_x;
			span_y_s1 <= span_y;
			cls_x_s1  <= cls_x;
			cls_y_s1  <= cls_y;
			size_x_s1 <= cfg.screen_width;
			size_y_s1 <= cfg.screen_height;
			margin_s1 <= cfg.edge_margin;
		end
	end

	// Scale the offsets; the quotient of num / span never exceeds the screen size of its axis
	assign num_x = PROD_W'(diff_x_s1) * PROD_W'(size_x_s1);
	assign num_y = PROD_W'(diff_y_s1) * PROD_W'(size_y_s1);

	always_comb begin
		item.x.rem  = num_x[PROD_W-1:SCR_W];
		item.x.rq   = num_x[SCR_W-1:0];
		item.x.span = span_x_s1;
		item.x.cls  = cls_x_s1;
		item.x.size = size_x_s1;
		item.y.rem  = num_y[PROD_W-1:SCR_W];
		item.y.rq   = num_y[SCR_W-1:0];
		item.y.span = span_y_s1;
		item.y.cls  = cls_y_s1;
		item.y.size = size_y_s1;
		item.margin = margin_s1;
	end

endmodule

`default_nettype wire

// File: rtl/core/cpm_queue.sv
// Two-entry queue between the mapper's front and back ends.
// Uses cpm_pkg for the item type.
`default_nettype none

module cpm_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire cpm_pkg::cpm_item_t  wr_item,
	input  wire logic                pop,
	output cpm_pkg::cpm_item_t       head,
	output cpm_pkg::cpm_qstat_t      qstat
);
	import cpm_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cpm_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign qstat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty at once");
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> !qstat.full)
		else $error("queue still full after a pop");
`endif

endmodule

`default_nettype wire

// File: rtl/core/cpm_back.sv
// Back end of the point mapper: pipelined long division on both axes, then
// the x clamp and the y inversion with lower bound. Uses cpm_pkg.
`default_nettype none

module cpm_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cpm_pkg::cpm_item_t        head,
	input  wire cpm_pkg::cpm_qstat_t       qstat,
	output logic                           pop,
	output logic                           done,
	output logic [cpm_pkg::SCR_W-1:0]      screen_x,
	output logic [cpm_pkg::SCR_W-1:0]      screen_y
);
	import cpm_pkg::*;

	cpm_item_t        div_s   [DIV_STAGES];
	cpm_item_t        div_nx  [DIV_STAGES];
	logic             vld_s   [DIV_STAGES];
	logic             done_q;
	logic [SCR_W-1:0] screen_x_q, screen_y_q;
	logic [SCR_W-1:0] map_x, map_y, clamp_x, clamp_y, inv_y;
	logic [SCR_W:0]   x_hi;
	cpm_item_t        last;

	// Never stalls: drain the queue whenever it holds an item
	assign pop = !qstat.empty;

	// Each stage retires BITS_PER_STAGE quotient bits per lane
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cpm_item_t src;
		logic      src_vld;
		if (g == 0) begin : g_first
			assign src     = head;
			assign src_vld = !qstat.empty;
		end else begin : g_rest
			assign src     = div_s[g-1];
			assign src_vld = vld_s[g-1];
		end

		always_comb begin
			div_nx[g] = src;
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				div_nx[g].x = lane_step(div_nx[g].x);
				div_nx[g].y = lane_step(div_nx[g].y);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			div_s[g] <= div_nx[g];
		end
	end

	assign last = div_s[DIV_STAGES-1];

	// Pick the mapped value per axis
	always_comb begin
		case (last.x.cls)
			MAP_DIV:  map_x = last.x.rq;
			MAP_FULL: map_x = last.x.size;
			default:  map_x = '0;
		endcase
		case (last.y.cls)
			MAP_DIV:  map_y = last.y.rq;
			MAP_FULL: map_y = last.y.size;
			default:  map_y = '0;
		endcase
	end

	// Clamp x, low bound first; invert y and raise it to the margin
	always_comb begin
		x_hi  = {1'b0, last.x.size} - (SCR_W+1)'(last.margin);
		inv_y = last.y.size - map_y;
		if (map_x < SCR_W'(last.margin)) begin
			clamp_x = SCR_W'(last.margin);
		end else if ({1'b0, map_x} > x_hi) begin
			clamp_x = x_hi[SCR_W-1:0];
		end else begin
			clamp_x = map_x;
		end
		if (inv_y < SCR_W'(last.margin)) begin
			clamp_y = SCR_W'(last.margin);
		end else begin
			clamp_y = inv_y;
		end
	end

	// Result strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		screen_x_q <= clamp_x;
		screen_y_q <= clamp_y;
	end

	assign done     = done_q;
	assign screen_x = screen_x_q;
	assign screen_y = screen_y_q;

endmodule

`default_nettype wire

// File: rtl/core/calibrated_point_mapper_unit.sv
// Calibrated point mapper: holds the configuration registers and joins the
// front end, the queue and the divider back end. Uses cpm_pkg.
// A point goes through the front stage, the queue, the divider and done_q.
// Throughput: a point per cycle if not busy; the 6-stage divider sets it.
// The receiver cannot stall; done lasts one cycle per result.
// Reset clears the pipeline and loads the calibration defaults.
`default_nettype none

module calibrated_point_mapper_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [cpm_pkg::RAW_W-1:0]     dot_x,
	input  wire logic [cpm_pkg::RAW_W-1:0]     dot_y,
	input  wire logic                          cfg_we,
	input  wire logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cpm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                               done,
	output logic [cpm_pkg::SCR_W-1:0]          screen_x,
	output logic [cpm_pkg::SCR_W-1:0]          screen_y
);
	import cpm_pkg::*;

	cpm_cfg_t   cfg_q;
	cpm_item_t  push_item, head;
	cpm_qstat_t qstat;
	logic       push, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_x_min     <= RAW_W'(0);
			cfg_q.cal_x_max     <= RAW_W'(1023);
			cfg_q.cal_y_min     <= RAW_W'(0);
			cfg_q.cal_y_max     <= RAW_W'(767);
			cfg_q.screen_width  <= SCR_W'(640);
			cfg_q.screen_height <= SCR_W'(480);
			cfg_q.edge_margin   <= MARGIN_W'(0);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_X_MIN:     cfg_q.cal_x_min     <= cfg_data[RAW_W-1:0];
				REG_CAL_X_MAX:     cfg_q.cal_x_max     <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MIN:     cfg_q.cal_y_min     <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MAX:     cfg_q.cal_y_max     <= cfg_data[RAW_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[SCR_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[SCR_W-1:0];
				REG_EDGE_MARGIN:   cfg_q.edge_margin   <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	cpm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dot_x  (dot_x),
		.dot_y  (dot_y),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.push   (push),
		.item   (push_item)
	);

	cpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	cpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.done     (done),
		.screen_x (screen_x),
		.screen_y (screen_y)
	);

endmodule

`default_nettype wire
